[sv/vector3_arithmetic_unit_macros.svh]
// assertion helpers shared by the vector unit
`ifndef VECTOR3_ARITHMETIC_UNIT_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define V3AU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define V3AU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/v3au_pkg.sv]
package v3au_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int WORD_BITS   = 32;
	localparam int QUO_BITS    = WORD_BITS + FRAC_BITS;
	localparam int ROOT_BITS   = WORD_BITS;
	localparam int RAD_BITS    = 2 * ROOT_BITS;
	localparam int PROD_BITS   = 2 * WORD_BITS;
	localparam int SAT_W       = PROD_BITS + 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [WORD_BITS-1:0] WMAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WMIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

	// command codes on the input word
	localparam logic [3:0] CMD_ADD   = 4'd0;
	localparam logic [3:0] CMD_SUB   = 4'd1;
	localparam logic [3:0] CMD_NEG   = 4'd2;
	localparam logic [3:0] CMD_SCALE = 4'd3;
	localparam logic [3:0] CMD_DIV   = 4'd4;
	localparam logic [3:0] CMD_DOT   = 4'd5;
	localparam logic [3:0] CMD_CROSS = 4'd6;
	localparam logic [3:0] CMD_MAG   = 4'd7;
	localparam logic [3:0] CMD_NORM  = 4'd8;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_DIV,
		OP_DOT, OP_CROSS, OP_MAG, OP_NORM, OP_NONE
	} op_t;

	typedef struct packed {
		logic [3:0]                  cmd;
		logic signed [WORD_BITS-1:0] a_x;
		logic signed [WORD_BITS-1:0] a_y;
		logic signed [WORD_BITS-1:0] a_z;
		logic signed [WORD_BITS-1:0] b_x;
		logic signed [WORD_BITS-1:0] b_y;
		logic signed [WORD_BITS-1:0] b_z;
		logic signed [WORD_BITS-1:0] scalar_in;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] r_x;
		logic signed [WORD_BITS-1:0] r_y;
		logic signed [WORD_BITS-1:0] r_z;
		logic signed [WORD_BITS-1:0] scalar_out;
		logic                        overflow_flag;
		logic                        div_zero_flag;
	} out_word_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t                        op;
		logic [2:0][WORD_BITS-1:0]  a;
		logic [2:0][WORD_BITS-1:0]  b;
		logic [WORD_BITS-1:0]       s;
		logic [2:0][WORD_BITS-1:0]  abs_a;
		logic [2:0]                 a_neg;
		logic [WORD_BITS-1:0]       abs_s;
		logic                       s_neg;
		logic                       s_zero;
	} cls_t;

	typedef struct packed {
		logic                 ovf;
		logic [WORD_BITS-1:0] val;
	} sat_t;

	function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
		sat_t r;
		r.ovf = 1'b0;
		r.val = v[WORD_BITS-1:0];
		if (v[SAT_W-1] && !(&v[SAT_W-1:WORD_BITS-1])) begin
			r.ovf = 1'b1;
			r.val = WMIN_W;
		end else if (!v[SAT_W-1] && (|v[SAT_W-1:WORD_BITS-1])) begin
			r.ovf = 1'b1;
			r.val = WMAX_W;
		end
		return r;
	endfunction

endpackage

[sv/v3au_stream_if.sv]
interface v3au_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/v3au_fifo.sv]
module v3au_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  v3au_pkg::cls_t wdata,
	input  logic           pop,
	output v3au_pkg::cls_t rdata,
	output logic           full,
	output logic           empty
);
	import v3au_pkg::*;

	cls_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

[sv/v3au_front.sv]
module v3au_front (
	input  logic           clk,
	input  logic           arst_n,
	v3au_stream_if.sink    req,
	output logic           push,
	output v3au_pkg::cls_t push_word,
	input  logic           full
);
	import v3au_pkg::*;

	logic fv_q;
	cls_t fw_q;
	cls_t cls;
	logic [2:0][WORD_BITS-1:0] av;

	assign req.ready = !fv_q || !full;
	assign push      = fv_q && !full;
	assign push_word = fw_q;

	assign av = {req.payload.a_z, req.payload.a_y, req.payload.a_x};

	// decode the command and prepare magnitudes and signs for the dividers
	always_comb begin
		cls = '0;
		unique case (req.payload.cmd)
			CMD_ADD:   cls.op = OP_ADD;
			CMD_SUB:   cls.op = OP_SUB;
			CMD_NEG:   cls.op = OP_NEG;
			CMD_SCALE: cls.op = OP_SCALE;
			CMD_DIV:   cls.op = OP_DIV;
			CMD_DOT:   cls.op = OP_DOT;
			CMD_CROSS: cls.op = OP_CROSS;
			CMD_MAG:   cls.op = OP_MAG;
			CMD_NORM:  cls.op = OP_NORM;
			default:   cls.op = OP_NONE;
		endcase
		cls.a = av;
		cls.b = {req.payload.b_z, req.payload.b_y, req.payload.b_x};
		cls.s = req.payload.scalar_in;
		for (int i = 0; i < 3; i++) begin
			cls.a_neg[i] = av[i][WORD_BITS-1];
			cls.abs_a[i] = av[i][WORD_BITS-1] ? (~av[i] + 1'b1) : av[i];
		end
		cls.s_neg  = req.payload.scalar_in[WORD_BITS-1];
		cls.s_zero = (req.payload.scalar_in == '0);
		cls.abs_s  = cls.s_neg ? (~req.payload.scalar_in + 1'b1) : req.payload.scalar_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else if (req.ready) begin
			fv_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			fw_q <= cls;
		end
	end
endmodule

[sv/v3au_back.sv]
`include "vector3_arithmetic_unit_macros.svh"

module v3au_back (
	input  logic           clk,
	input  logic           arst_n,
	input  v3au_pkg::cls_t head,
	input  logic           head_valid,
	output logic           pop,
	v3au_stream_if.source  rsp
);
	import v3au_pkg::*;

	localparam int SQ_STEPS = ROOT_BITS;
	localparam int SETUP    = SQ_STEPS + 1;
	localparam int LAST     = SETUP + QUO_BITS;

	typedef struct packed {
		op_t                        op;
		logic [2:0][WORD_BITS-1:0]  r;
		logic [WORD_BITS-1:0]       sc;
		logic                       ovf;
		logic                       dz;
		logic [2:0][QUO_BITS-1:0]   quo;
		logic [2:0][WORD_BITS-1:0]  drem;
		logic [2:0]                 qneg;
		logic [WORD_BITS-1:0]       den;
		logic [RAD_BITS-1:0]        rad;
		logic [ROOT_BITS+2:0]       rem;
		logic [ROOT_BITS-1:0]       root;
	} bk_t;

	// one root bit per step
	function automatic bk_t sq_step(input bk_t x);
		bk_t y;
		logic [ROOT_BITS+4:0] rem2;
		logic [ROOT_BITS+4:0] trial;
		y     = x;
		rem2  = {x.rem, x.rad[RAD_BITS-1 -: 2]};
		trial = rem2 - {3'b000, x.root, 2'b01};
		y.rad = {x.rad[RAD_BITS-3:0], 2'b00};
		if (!trial[ROOT_BITS+4]) begin
			y.rem  = trial[ROOT_BITS+2:0];
			y.root = {x.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			y.rem  = rem2[ROOT_BITS+2:0];
			y.root = {x.root[ROOT_BITS-2:0], 1'b0};
		end
		return y;
	endfunction

	// pick the divisor, finish magnitude
	function automatic bk_t setup_step(input bk_t x);
		bk_t y;
		y = x;
		if (x.op == OP_NORM) begin
			y.den = x.root;
		end
		if (x.op == OP_MAG) begin
			y.sc  = x.root[ROOT_BITS-1] ? WMAX_W : x.root;
			y.ovf = x.root[ROOT_BITS-1];
		end
		return y;
	endfunction

	// one quotient bit per step on all three lanes
	function automatic bk_t dv_step(input bk_t x);
		bk_t y;
		logic [WORD_BITS:0] rem2;
		logic [WORD_BITS:0] diff;
		y = x;
		for (int i = 0; i < 3; i++) begin
			rem2 = {x.drem[i], x.quo[i][QUO_BITS-1]};
			diff = rem2 - {1'b0, x.den};
			if (rem2 >= {1'b0, x.den}) begin
				y.drem[i] = diff[WORD_BITS-1:0];
				y.quo[i]  = {x.quo[i][QUO_BITS-2:0], 1'b1};
			end else begin
				y.drem[i] = rem2[WORD_BITS-1:0];
				y.quo[i]  = {x.quo[i][QUO_BITS-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic                         en;
	logic                         v_s1;
	cls_t                         w_s1;
	logic signed [PROD_BITS-1:0]  pm_s1 [3];
	logic signed [PROD_BITS-1:0]  pn_s1 [3];
	logic signed [WORD_BITS-1:0]  ml [3];
	logic signed [WORD_BITS-1:0]  mr [3];
	logic signed [WORD_BITS-1:0]  nl [3];
	logic signed [WORD_BITS-1:0]  nr [3];

	logic signed [SAT_W-1:0]      wv [3];
	logic signed [SAT_W-1:0]      wd;
	sat_t                         sv [3];
	sat_t                         sd;
	bk_t                          c_nxt;

	logic [LAST:0]                vld_s;
	bk_t                          pipe_s [LAST+1];

	logic [SAT_W-1:0]             qw [3];
	logic signed [SAT_W-1:0]      qv [3];
	sat_t                         qs [3];
	out_word_t                    fin;
	out_word_t                    out_q;
	logic                         ov_q;

	assign en          = !ov_q || rsp.ready;
	assign pop         = en && head_valid;
	assign rsp.valid   = ov_q;
	assign rsp.payload = out_q;

	// multiplier operand selection
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ml[i] = $signed(head.a[i]);
			nl[i] = '0;
			nr[i] = '0;
			if (head.op == OP_SCALE) begin
				mr[i] = $signed(head.s);
			end else if (head.op == OP_MAG || head.op == OP_NORM) begin
				mr[i] = $signed(head.a[i]);
			end else begin
				mr[i] = $signed(head.b[i]);
			end
		end
		if (head.op == OP_CROSS) begin
			ml[0] = $signed(head.a[1]); mr[0] = $signed(head.b[2]);
			nl[0] = $signed(head.a[2]); nr[0] = $signed(head.b[1]);
			ml[1] = $signed(head.a[2]); mr[1] = $signed(head.b[0]);
			nl[1] = $signed(head.a[0]); nr[1] = $signed(head.b[2]);
			ml[2] = $signed(head.a[0]); mr[2] = $signed(head.b[1]);
			nl[2] = $signed(head.a[1]); nr[2] = $signed(head.b[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= head;
			for (int i = 0; i < 3; i++) begin
				pm_s1[i] <= ml[i] * mr[i];
				pn_s1[i] <= nl[i] * nr[i];
			end
		end
	end

	// wide sums and shifts, then saturation
	always_comb begin
		wd = (SAT_W'(pm_s1[0]) + SAT_W'(pm_s1[1]) + SAT_W'(pm_s1[2])) >>> FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			unique case (w_s1.op)
				OP_ADD:   wv[i] = SAT_W'($signed(w_s1.a[i])) + SAT_W'($signed(w_s1.b[i]));
				OP_SUB:   wv[i] = SAT_W'($signed(w_s1.a[i])) - SAT_W'($signed(w_s1.b[i]));
				OP_NEG:   wv[i] = -SAT_W'($signed(w_s1.a[i]));
				OP_SCALE: wv[i] = SAT_W'(pm_s1[i]) >>> FRAC_BITS;
				OP_CROSS: wv[i] = (SAT_W'(pm_s1[i]) - SAT_W'(pn_s1[i])) >>> FRAC_BITS;
				default:  wv[i] = '0;
			endcase
			sv[i] = sat_word(wv[i]);
		end
		sd = sat_word(wd);
	end

	always_comb begin
		c_nxt     = '0;
		c_nxt.op  = w_s1.op;
		c_nxt.den = w_s1.abs_s;
		c_nxt.rad = $unsigned(pm_s1[0]) + $unsigned(pm_s1[1]) + $unsigned(pm_s1[2]);
		for (int i = 0; i < 3; i++) begin
			c_nxt.quo[i]  = {w_s1.abs_a[i], {FRAC_BITS{1'b0}}};
			c_nxt.qneg[i] = (w_s1.op == OP_DIV) ? (w_s1.a_neg[i] ^ w_s1.s_neg)
				: w_s1.a_neg[i];
		end
		unique case (w_s1.op)
			OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					c_nxt.r[i] = sv[i].val;
				end
				c_nxt.ovf = sv[0].ovf | sv[1].ovf | sv[2].ovf;
			end
			OP_DOT: begin
				c_nxt.sc  = sd.val;
				c_nxt.ovf = sd.ovf;
			end
			OP_DIV: begin
				// zero divisor: signed limit by the sign of each nonzero component, zero otherwise
				if (w_s1.s_zero) begin
					c_nxt.dz = 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (w_s1.a_neg[i]) begin
							c_nxt.r[i] = WMIN_W;
						end else if (w_s1.abs_a[i] != '0) begin
							c_nxt.r[i] = WMAX_W;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= c_nxt;
		end
	end

	for (genvar k = 1; k <= LAST; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		if (k <= SQ_STEPS) begin : g_sq
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= sq_step(pipe_s[k-1]);
				end
			end
		end else if (k == SETUP) begin : g_setup
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= setup_step(pipe_s[k-1]);
				end
			end
		end else begin : g_dv
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= dv_step(pipe_s[k-1]);
				end
			end
		end
	end

	// sign and saturate quotients, merge with results computed up front
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qw[i] = SAT_W'(pipe_s[LAST].quo[i]);
			qv[i] = pipe_s[LAST].qneg[i] ? -qw[i] : qw[i];
			qs[i] = sat_word(qv[i]);
		end
		fin.scalar_out    = pipe_s[LAST].sc;
		fin.div_zero_flag = pipe_s[LAST].dz;
		if ((pipe_s[LAST].op == OP_DIV || pipe_s[LAST].op == OP_NORM)
			&& pipe_s[LAST].den != '0) begin
			fin.r_x           = qs[0].val;
			fin.r_y           = qs[1].val;
			fin.r_z           = qs[2].val;
			fin.overflow_flag = qs[0].ovf | qs[1].ovf | qs[2].ovf;
		end else begin
			fin.r_x           = pipe_s[LAST].r[0];
			fin.r_y           = pipe_s[LAST].r[1];
			fin.r_z           = pipe_s[LAST].r[2];
			fin.overflow_flag = pipe_s[LAST].ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= fin;
		end
	end

	`V3AU_ASSERT_NEXT(a_stall_holds_pipe, !en, vld_s == $past(vld_s), "pipeline moved while stalled")
	`V3AU_ASSERT_NOW(a_dz_no_ovf, ov_q && out_q.div_zero_flag, !out_q.overflow_flag, "dz with overflow")
	`V3AU_ASSERT_NOW(a_dz_no_scalar, ov_q && out_q.div_zero_flag, out_q.scalar_out == '0, "dz with scalar")
endmodule

[sv/vector3_arithmetic_unit.sv]
// Three-component vector unit in signed Q16.16: add, subtract, negate, scale,
// divide by scalar, dot, cross, magnitude and normalize, one result word per
// command word. A front stage decodes each word and feeds a four-word queue;
// the back pipeline takes one word per cycle from the queue and stalls as a
// whole only when its output register holds a word nobody has taken. With
// the result side ready, a new word is accepted every cycle. Every command
// passes through the whole back pipeline, so that results leave in order:
// one multiply stage, one sum stage, 32 square root stages (one root bit
// each), a divisor select stage and 48 restoring divide stages (one
// quotient bit each, three lanes). Saturation raises overflow_flag; a divide
// by zero gives the signed limit per nonzero component and raises
// div_zero_flag; normalize of a zero vector gives zero with no flag; unused
// commands give an all-zero word.
module vector3_arithmetic_unit (
	input logic           clk,
	input logic           arst_n,
	v3au_stream_if.sink   req,
	v3au_stream_if.source rsp
);
	import v3au_pkg::*;

	// front to queue
	logic push;
	cls_t push_word;
	logic full;

	// queue to back
	cls_t head;
	logic empty;
	logic pop;

	v3au_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	v3au_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_word),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	v3au_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.rsp        (rsp)
	);
endmodule
